// ----- sv/ntv_pkg.sv -----
// ----------------------------------------------------------------------------
// ntv_pkg: shared types and constants for the numeric text validator
// character codes, scan phase encoding and the payload width
// ----------------------------------------------------------------------------
package ntv_pkg;

  localparam int CH_W = 8;

  typedef logic [CH_W-1:0] ch_t;

  // character codes
  localparam ch_t CH_NUL   = 8'h00;
  localparam ch_t CH_SPACE = 8'h20;
  localparam ch_t CH_TAB   = 8'h09;
  localparam ch_t CH_PLUS  = 8'h2b;
  localparam ch_t CH_MINUS = 8'h2d;
  localparam ch_t CH_POINT = 8'h2e;
  localparam ch_t CH_EXP_L = 8'h65;
  localparam ch_t CH_EXP_U = 8'h45;
  localparam ch_t CH_ZERO  = 8'h30;
  localparam ch_t CH_NINE  = 8'h39;

  // recognizer phases
  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_SIGN   = 4'd1,
    PH_INT    = 4'd2,
    PH_PT     = 4'd3,
    PH_FRAC   = 4'd4,
    PH_EXP    = 4'd5,
    PH_ESIGN  = 4'd6,
    PH_EDIG   = 4'd7,
    PH_TRAIL  = 4'd8,
    PH_REJECT = 4'd9
  } phase_t;

endpackage

// ----- sv/numeric_text_validator_unit.sv -----
// ----------------------------------------------------------------------------
// numeric_text_validator_unit: decimal number literal recognizer
// walks one character per request through a small automaton and reports,
// at each zero terminator, whether the string was a decimal number
// ----------------------------------------------------------------------------
// output: a verdict is registered into the result buffer when its terminator is accepted
// throughput: one character per cycle while the skid entry is empty, set by the single phase register
// a two-entry result buffer keeps input flowing while a verdict waits
// reset: synchronous active-low; phase returns to leading whitespace and
// the result buffer empties
module numeric_text_validator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ntv_pkg::CH_W-1:0]  in_ch,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_is_number
);

  import ntv_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_r, out_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  logic   skid_r, skid_nxt;

  logic   accept, is_term, push, drain, verdict;
  logic   is_digit, is_blank, is_sign, is_exp, is_point;

  // character classes
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_blank = (in_ch == CH_SPACE) || (in_ch == CH_TAB);
  assign is_sign  = (in_ch == CH_PLUS) || (in_ch == CH_MINUS);
  assign is_exp   = (in_ch == CH_EXP_L) || (in_ch == CH_EXP_U);
  assign is_point = (in_ch == CH_POINT);

  // handshake
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign is_term  = (in_ch == CH_NUL);
  assign push     = accept && is_term;
  assign drain    = out_valid_r && !out_stall;

  // accepting phases
  always_comb begin
    case (phase_r) inside
      PH_INT, PH_FRAC, PH_EDIG, PH_TRAIL: verdict = 1'b1;
      default:                            verdict = 1'b0;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (is_term) begin
        phase_nxt = PH_LEAD;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (is_blank)      phase_nxt = PH_LEAD;
            else if (is_sign)  phase_nxt = PH_SIGN;
            else if (is_digit) phase_nxt = PH_INT;
            else if (is_point) phase_nxt = PH_PT;
            else               phase_nxt = PH_REJECT;
          end
          PH_SIGN: begin
            if (is_digit)      phase_nxt = PH_INT;
            else if (is_point) phase_nxt = PH_PT;
            else               phase_nxt = PH_REJECT;
          end
          PH_INT: begin
            if (is_digit)      phase_nxt = PH_INT;
            else if (is_point) phase_nxt = PH_FRAC;
            else if (is_exp)   phase_nxt = PH_EXP;
            else if (is_blank) phase_nxt = PH_TRAIL;
            else               phase_nxt = PH_REJECT;
          end
          PH_PT: begin
            if (is_digit)      phase_nxt = PH_FRAC;
            else               phase_nxt = PH_REJECT;
          end
          PH_FRAC: begin
            if (is_digit)      phase_nxt = PH_FRAC;
            else if (is_exp)   phase_nxt = PH_EXP;
            else if (is_blank) phase_nxt = PH_TRAIL;
            else               phase_nxt = PH_REJECT;
          end
          PH_EXP: begin
            if (is_sign)       phase_nxt = PH_ESIGN;
            else if (is_digit) phase_nxt = PH_EDIG;
            else               phase_nxt = PH_REJECT;
          end
          PH_ESIGN: begin
            if (is_digit)      phase_nxt = PH_EDIG;
            else               phase_nxt = PH_REJECT;
          end
          PH_EDIG: begin
            if (is_digit)      phase_nxt = PH_EDIG;
            else if (is_blank) phase_nxt = PH_TRAIL;
            else               phase_nxt = PH_REJECT;
          end
          PH_TRAIL: begin
            if (is_blank)      phase_nxt = PH_TRAIL;
            else               phase_nxt = PH_REJECT;
          end
          default: begin
            phase_nxt = PH_REJECT;
          end
        endcase
      end
    end
  end

  // result buffer: output register plus skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (drain) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || drain) begin
        out_valid_nxt = 1'b1;
        out_nxt       = verdict;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = verdict;
      end
    end else if (drain) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_number = out_r;

endmodule
